[design/mpow_pkg.sv]
`timescale 1ns / 1ps
package mpow_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_ID_BITS_DEF = 16;
    localparam int PERIOD_BITS = 32;
    localparam logic REQ_LOCK = 1'b0;
    localparam logic REQ_UNLOCK = 1'b1;
endpackage

[design/mpow_if.sv]
`timescale 1ns / 1ps
interface mpow_in_if #(parameter int ID_BITS = 16) ();
    logic valid;
    logic ready;
    logic req_type;
    logic [ID_BITS-1:0] task_id;
    logic [31:0] task_period;
    modport source (output valid, req_type, task_id, task_period, input ready);
    modport sink (input valid, req_type, task_id, task_period, output ready);
endinterface

interface mpow_out_if #(parameter int ID_BITS = 16) ();
    logic valid;
    logic ready;
    logic granted;
    logic woken_valid;
    logic [ID_BITS-1:0] woken_task;
    logic queue_overflow;
    modport source (output valid, granted, woken_valid, woken_task, queue_overflow,
                    input ready);
    modport sink (input valid, granted, woken_valid, woken_task, queue_overflow,
                  output ready);
endinterface

[design/mutex_with_period_ordered_waiters_top.sv]
`timescale 1ns / 1ps
// Hardware mutex with a wait queue kept in ascending period order.
// The in channel carries one request: req_type (lock or unlock), task_id and
// task_period. The out channel returns exactly one result per request:
// granted, woken_valid, woken_task and queue_overflow.
// A lock request on a free lock is granted; on a held lock the requester is
// inserted behind all waiters of equal or smaller period, or flagged as
// overflow when the queue is full. An unlock frees the lock and releases the
// head waiter, whose task must issue its lock request again.
// A request passes through the front queue register and then the back
// stage, where all queue cells compare and shift in parallel; one request
// is accepted per cycle while the output is taken.
// Reset frees the lock and empties the queue; no clearing pass is needed.
// When the receiver stalls, the result is held, the back stage stops, and
// the front register holds one further request before the input stalls.
module mutex_with_period_ordered_waiters_top #(
    parameter int QUEUE_DEPTH = mpow_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = mpow_pkg::TASK_ID_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    mpow_in_if.sink in_ch,
    mpow_out_if.source out_ch
);
    import mpow_pkg::*;

    logic q_valid, q_ready, q_req;
    logic [TASK_ID_BITS-1:0] q_id;
    logic [PERIOD_BITS-1:0] q_period;

    mpow_front #(.ID_BITS(TASK_ID_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .q_id(q_id), .q_period(q_period)
    );

    mpow_back #(.DEPTH(QUEUE_DEPTH), .ID_BITS(TASK_ID_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .q_id(q_id), .q_period(q_period), .out_ch(out_ch)
    );
endmodule

[design/mpow_front.sv]
`timescale 1ns / 1ps
module mpow_front #(
    parameter int ID_BITS = mpow_pkg::TASK_ID_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mpow_in_if.sink in_ch,
    output logic q_valid,
    input  logic q_ready,
    output logic q_req,
    output logic [ID_BITS-1:0] q_id,
    output logic [31:0] q_period
);
    import mpow_pkg::*;

    // Single-entry request queue between front and back.
    logic full_reg;
    logic req_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [PERIOD_BITS-1:0] period_reg;

    assign in_ch.ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_req = req_reg;
    assign q_id = id_reg;
    assign q_period = period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            full_reg <= 1'b1;
        end
        else if (q_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            req_reg <= in_ch.req_type;
            id_reg <= in_ch.task_id;
            period_reg <= in_ch.task_period;
        end
    end
endmodule

[design/mpow_back.sv]
`timescale 1ns / 1ps
module mpow_back #(
    parameter int DEPTH = mpow_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS = mpow_pkg::TASK_ID_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  logic q_req,
    input  logic [ID_BITS-1:0] q_id,
    input  logic [31:0] q_period,
    mpow_out_if.source out_ch
);
    import mpow_pkg::*;
    localparam int CW = $clog2(DEPTH + 1);

    logic lock_reg;
    logic [CW-1:0] count_reg;
    logic [ID_BITS-1:0] ids_reg [DEPTH];
    logic [PERIOD_BITS-1:0] per_reg [DEPTH];
    logic ov_reg;
    logic granted_reg, woken_reg, overflow_reg;
    logic [ID_BITS-1:0] wtask_reg;
    logic [DEPTH-1:0] occ;
    logic [DEPTH-1:0] after;
    logic go, do_ins, do_rem;

    assign q_ready = !ov_reg || out_ch.ready;
    assign go = q_valid && q_ready;
    assign do_ins = go && q_req == REQ_LOCK && lock_reg && count_reg < CW'(DEPTH);
    assign do_rem = go && q_req == REQ_UNLOCK && count_reg != '0;

    // Each cell compares its period with the new one; the sorted queue shifts in place.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i] = CW'(i) < count_reg;
            after[i] = occ[i] && (per_reg[i] > q_period);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_ins)
            begin
                if (after[i])
                begin
                    if (i + 1 < DEPTH)
                    begin
                        ids_reg[(i + 1) % DEPTH] <= ids_reg[i];
                        per_reg[(i + 1) % DEPTH] <= per_reg[i];
                    end
                end
                if (!occ[i] || after[i])
                begin
                    if (i == 0 || (occ[(i + DEPTH - 1) % DEPTH]
                                   && !after[(i + DEPTH - 1) % DEPTH]))
                    begin
                        ids_reg[i] <= q_id;
                        per_reg[i] <= q_period;
                    end
                end
            end
            else if (do_rem && i + 1 < DEPTH)
            begin
                ids_reg[i] <= ids_reg[(i + 1) % DEPTH];
                per_reg[i] <= per_reg[(i + 1) % DEPTH];
            end
        end
        if (go)
        begin
            granted_reg <= q_req == REQ_LOCK && !lock_reg;
            overflow_reg <= q_req == REQ_LOCK && lock_reg && count_reg >= CW'(DEPTH);
            woken_reg <= do_rem;
            wtask_reg <= do_rem ? ids_reg[0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= 1'b0;
            count_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                lock_reg <= q_req == REQ_LOCK;
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (do_ins)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rem)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.granted = granted_reg;
    assign out_ch.woken_valid = woken_reg;
    assign out_ch.woken_task = wtask_reg;
    assign out_ch.queue_overflow = overflow_reg;
endmodule
